/* hw/rtl/indexed_list_insert_remove_top_assert.svh */
// Assertion macros for the indexed list block.
`ifndef INDEXED_LIST_INSERT_REMOVE_TOP_ASSERT_SVH
`define INDEXED_LIST_INSERT_REMOVE_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ILIR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ILIR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/ilir_pkg.sv */
package ilir_pkg;

  localparam int unsigned POS_W    = 7;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned SIZE_W   = 7;
  localparam int unsigned CAP_W    = 7;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_POP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  // register index 0: capacity limit
  localparam logic REG_CAP = 1'b0;

  typedef struct packed {
    logic [1:0]        command;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] data_in;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [WORD_W-1:0] data_out;
    logic [SIZE_W-1:0] size_after;
  } out_word_t;

  // broadcast to every cell; both low means hold
  typedef struct packed {
    logic grow;    // insert or append accepted
    logic shrink;  // remove or pop accepted
  } row_ctl_t;

endpackage

/* hw/rtl/ilir_cell.sv */
module ilir_cell #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned CNT_W      = 7,
  parameter int unsigned INDEX      = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ilir_pkg::row_ctl_t    ctl_i,
  input  logic [CNT_W-1:0]      target_i,
  input  logic [CNT_W-1:0]      count_i,
  input  logic [DATA_WIDTH-1:0] word_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  output logic [DATA_WIDTH-1:0] q_o,
  output logic [DATA_WIDTH-1:0] tap_o
);
  import ilir_pkg::*;

  localparam logic [CNT_W-1:0] Idx  = CNT_W'(INDEX);
  localparam logic [CNT_W-1:0] Next = CNT_W'(INDEX + 1);

  logic [DATA_WIDTH-1:0] entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.grow) begin
      if (Idx == target_i) begin
        entry_d = word_i;
      end else if (Idx > target_i && Idx <= count_i) begin
        entry_d = left_i;
      end
    end else if (ctl_i.shrink) begin
      if (Next == count_i) begin
        entry_d = '0;  // vacated slot
      end else if (Idx >= target_i && Next < count_i) begin
        entry_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign q_o   = entry_q;
  assign tap_o = (Idx == target_i) ? entry_q : '0;

endmodule

/* hw/rtl/ilir_row.sv */
module ilir_row #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned CNT_W      = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ilir_pkg::row_ctl_t    ctl_i,
  input  logic [CNT_W-1:0]      target_i,
  input  logic [CNT_W-1:0]      count_i,
  input  logic [DATA_WIDTH-1:0] word_i,
  output logic [DATA_WIDTH-1:0] taken_o
);
  import ilir_pkg::*;

  logic [DEPTH-1:0][DATA_WIDTH-1:0] q;
  logic [DEPTH-1:0][DATA_WIDTH-1:0] tap;
  logic [DATA_WIDTH-1:0][DEPTH-1:0] tap_col;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left, right;

    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_inner_l
      assign left = q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner_r
      assign right = q[i+1];
    end

    ilir_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .INDEX      (i)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl_i),
      .target_i (target_i),
      .count_i  (count_i),
      .word_i   (word_i),
      .left_i   (left),
      .right_i  (right),
      .q_o      (q[i]),
      .tap_o    (tap[i])
    );

    for (genvar b = 0; b < DATA_WIDTH; b++) begin : g_bit
      assign tap_col[b][i] = tap[i][b];
    end
  end

  // at most one cell taps, so an OR per bit picks its word
  for (genvar b = 0; b < DATA_WIDTH; b++) begin : g_or
    assign taken_o[b] = |tap_col[b];
  end

endmodule

/* hw/rtl/indexed_list_insert_remove_top.sv */
// Channel | Direction | Handshake               | Word
// in      | input     | in_valid_i / in_stall_o | in_word_i  (command, position, data_in)
// out     | output    | out_valid_o/out_stall_i | out_word_o (status, data_out, size_after)
// cfg     | input     | psel/penable/pready     | paddr, pwdata, prdata (capacity limit)
//
// The whole row of cells shifts, loads or clears in the single edge at
// which the command is accepted, so a command may follow in the next cycle
// unless a result is stalled. The result enters the output register at that edge.
// Reset clears every cell, the entry count and the output valid, and sets
// the capacity limit to 64. No clearing pass is needed after reset.
// A stalled result blocks the input only while it is still held.
module indexed_list_insert_remove_top #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // command channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  ilir_pkg::in_word_t                in_word_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output ilir_pkg::out_word_t               out_word_o,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ilir_pkg::PADDR_W-1:0]      paddr,
  input  logic [ilir_pkg::PDATA_W-1:0]      pwdata,
  output logic [ilir_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);
  import ilir_pkg::*;

  // count runs 0..DEPTH; comparisons against the 7-bit position and limit
  // are done at the wider of the two widths
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CAP_W-1:0] cap_q;
  logic             out_valid_q;
  out_word_t        out_word_q;

  logic             in_acc;
  logic             cfg_wr;
  cmd_e             cmd;
  logic [CMP_W-1:0] pos_w, cnt_w, cap_w;
  logic             full;
  status_e          status;
  row_ctl_t         ctl;
  logic [CNT_W-1:0] target;
  logic [63:0]      din_ext, taken_ext;
  logic [DATA_WIDTH-1:0] word, taken;
  logic [CMP_W-1:0] size_w;

  // ---- handshake: output register parts the two sides ----
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  // ---- register port ----
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == REG_CAP) ? PDATA_W'(cap_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_wr && paddr[2] == REG_CAP) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  // ---- command decode and checks ----
  assign cmd   = cmd_e'(in_word_i.command);
  assign pos_w = CMP_W'(in_word_i.position);
  assign cnt_w = CMP_W'(cnt_q);
  assign cap_w = CMP_W'(cap_q);

  // count >= min(limit, DEPTH)
  assign full = (cnt_w >= cap_w) || (cnt_q >= CNT_W'(DEPTH));

  always_comb begin
    status      = ST_OK;
    ctl.grow    = 1'b0;
    ctl.shrink  = 1'b0;
    target      = cnt_q;
    cnt_d       = cnt_q;
    case (cmd)
      CMD_INSERT: begin
        target = pos_w[CNT_W-1:0];
        if (pos_w > cnt_w) begin
          status = ST_RANGE;   // range check ahead of full check
        end else if (full) begin
          status = ST_FULL;
        end else begin
          ctl.grow = 1'b1;
        end
      end
      CMD_APPEND: begin
        target = cnt_q;
        if (full) begin
          status = ST_FULL;
        end else begin
          ctl.grow = 1'b1;
        end
      end
      CMD_REMOVE: begin
        target = pos_w[CNT_W-1:0];
        if (cnt_q == '0) begin
          status = ST_EMPTY;
        end else if (pos_w >= cnt_w) begin
          status = ST_RANGE;
        end else begin
          ctl.shrink = 1'b1;
        end
      end
      CMD_POP: begin
        target = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          status = ST_EMPTY;
        end else begin
          ctl.shrink = 1'b1;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
    if (ctl.grow) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (ctl.shrink) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
    // row only moves on an accepted command
    ctl.grow   = ctl.grow & in_acc;
    ctl.shrink = ctl.shrink & in_acc;
  end

  // word stored modulo 2^DATA_WIDTH, taken word cut to 32 bits
  assign din_ext   = 64'(in_word_i.data_in);
  assign word      = din_ext[DATA_WIDTH-1:0];
  assign taken_ext = 64'(taken);
  assign size_w    = CMP_W'(cnt_d);

  // ---- row of cells ----
  ilir_row #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .CNT_W      (CNT_W)
  ) u_row (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .target_i (target),
    .count_i  (cnt_q),
    .word_i   (word),
    .taken_o  (taken)
  );

  // ---- count and result register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        cnt_q <= cnt_d;
      end
      out_valid_q <= in_acc | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_word_q.status     <= status;
      out_word_q.data_out   <= ctl.shrink ? taken_ext[WORD_W-1:0] : '0;
      out_word_q.size_after <= size_w[SIZE_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // ---- checks ----
`include "indexed_list_insert_remove_top_assert.svh"

  `ILIR_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(DEPTH), "entry count beyond store")
  `ILIR_ASSERT_NEXT(a_grow_cnt, ctl.grow, cnt_q == $past(cnt_q) + CNT_W'(1), "grow lost count")
  `ILIR_ASSERT_NEXT(a_shrink_cnt, ctl.shrink, cnt_q == $past(cnt_q) - CNT_W'(1), "shrink lost count")
  `ILIR_ASSERT_NOW(a_err_no_data, out_valid_q && out_word_q.status != ST_OK, out_word_q.data_out == '0, "data on refused command")
  `ILIR_ASSERT_NOW(a_row_idle, !in_acc, !ctl.grow && !ctl.shrink, "row moved without command")

endmodule

/* tb/indexed_list_checker.sv */
module indexed_list_checker #(
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cmd_valid_i,
  input  logic                                 cmd_stall_i,
  input  ilir_pkg::in_word_t                   cmd_word_i,
  input  logic                                 res_valid_i,
  input  logic                                 res_stall_i,
  input  ilir_pkg::out_word_t                  res_word_i,
  input  logic                                 psel_i,
  input  logic                                 penable_i,
  input  logic                                 pwrite_i,
  input  logic                                 pready_i,
  input  logic [ilir_pkg::PADDR_W-1:0]         paddr_i,
  input  logic [ilir_pkg::PDATA_W-1:0]         pwdata_i,
  output int unsigned                          fail_count_o,
  output int unsigned                          pending_o,
  output int unsigned                          list_size_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ilir_pkg::*;

  localparam logic [WORD_W-1:0] DMASK =
    (DATA_WIDTH >= WORD_W) ? '1 : ((WORD_W'(1) << DATA_WIDTH) - 1);

  // shadow of the list
  logic [WORD_W-1:0] slots [DEPTH];
  int unsigned       fill;
  logic [CAP_W-1:0]  cap_limit;
  out_word_t         result_q [$];
  int unsigned       mism;

  task automatic apply_command(input in_word_t w, output out_word_t r);
    int unsigned lim;
    int unsigned p;
    int          i;
    lim = (cap_limit > DEPTH) ? DEPTH : cap_limit;
    p = w.position;
    r.status   = ST_OK;
    r.data_out = '0;
    case (cmd_e'(w.command))
      CMD_INSERT: begin
        if (p > fill) r.status = ST_RANGE;
        else if (fill >= lim) r.status = ST_FULL;
        else begin
          for (i = fill; i > p; i--) slots[i] = slots[i-1];
          slots[p] = w.data_in & DMASK;
          fill++;
        end
      end
      CMD_APPEND: begin
        if (fill >= lim) r.status = ST_FULL;
        else begin
          slots[fill] = w.data_in & DMASK;
          fill++;
        end
      end
      CMD_REMOVE: begin
        if (fill == 0) r.status = ST_EMPTY;
        else if (p >= fill) r.status = ST_RANGE;
        else begin
          r.data_out = slots[p];
          for (i = p; i + 1 < fill; i++) slots[i] = slots[i+1];
          slots[fill-1] = '0;
          fill--;
        end
      end
      default: begin
        if (fill == 0) r.status = ST_EMPTY;
        else begin
          r.data_out = slots[fill-1];
          slots[fill-1] = '0;
          fill--;
        end
      end
    endcase
    r.size_after = SIZE_W'(fill);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    out_word_t got;
    if (!rst_ni) begin
      foreach (slots[k]) slots[k] = '0;
      fill      = 0;
      cap_limit = CAP_RESET;
      result_q.delete();
      mism      = 0;
    end else begin
      // result side first: a word accepted now cannot answer this edge
      if (res_valid_i && !res_stall_i) begin
        got = res_word_i;
        if (result_q.size() == 0) begin
          mism++;
          $display("%0t: result expected none actual status=%0d data=%h size=%0d",
                   $time, got.status, got.data_out, got.size_after);
        end else begin
          want = result_q.pop_front();
          if (got.status !== want.status) begin
            mism++;
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, got.status);
          end
          if (got.data_out !== want.data_out) begin
            mism++;
            $display("%0t: data_out expected %h actual %h", $time,
                     want.data_out, got.data_out);
          end
          if (got.size_after !== want.size_after) begin
            mism++;
            $display("%0t: size_after expected %0d actual %0d", $time,
                     want.size_after, got.size_after);
          end
        end
      end
      if (cmd_valid_i && !cmd_stall_i) begin
        apply_command(cmd_word_i, want);
        result_q.push_back(want);
      end
      if (psel_i && penable_i && pwrite_i && pready_i &&
          paddr_i[PADDR_W-1:2] == REG_CAP)
        cap_limit = pwdata_i[CAP_W-1:0];
    end
    fail_count_o <= mism;
    pending_o    <= result_q.size();
    list_size_o  <= fill;
  end

endmodule

/* tb/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ilir_pkg::*;

  localparam int unsigned LIMIT      = 300_000;
  localparam int unsigned LONG_HOLD  = 80;
  // second register slot: nothing lives there, writes must be dropped
  localparam logic [PADDR_W-1:0] ADDR_UNUSED = 3'd4;
  localparam logic [PADDR_W-1:0] ADDR_CAP    = {REG_CAP, 2'b00};

  typedef enum int {MIX_GROW, MIX_EVEN, MIX_SHRINK} mix_e;

  logic                clk     = 1'b0;
  logic                rst_n   = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_word_t            in_word = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_word_t           out_word;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [PADDR_W-1:0]  paddr   = '0;
  logic [PDATA_W-1:0]  pwdata  = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned list_size;
  int unsigned cycles = 0;

  // idling switches, flipped by the stimulus flow
  bit tx_idle_en = 1'b0;
  bit rx_idle_en = 1'b0;
  bit long_hold_req = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  indexed_list_insert_remove_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  indexed_list_checker chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cmd_valid_i  (in_valid),
    .cmd_stall_i  (in_stall),
    .cmd_word_i   (in_word),
    .res_valid_i  (out_valid),
    .res_stall_i  (out_stall),
    .res_word_i   (out_word),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .list_size_o  (list_size)
  );

  // Watchdog: a hung handshake or a lost result ends up here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side stall. One NBA per edge: a countdown decides the level,
  // and a new burst is only chosen once the previous one has run out.
  // The long hold-off lets the output register fill and back up the input.
  initial begin : rx_stall_gen
    int unsigned left;
    left = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (left > 0) begin
        out_stall <= 1'b1;
        left--;
      end else begin
        out_stall <= 1'b0;
        if (long_hold_req) begin
          long_hold_req = 1'b0;
          left = LONG_HOLD;
        end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
          left = $urandom_range(1, 14);
        end
      end
    end
  end

  // Offer one word and hold it until taken. Called at a rising edge;
  // returns at the edge of acceptance with valid still high.
  task automatic send_word(input in_word_t w);
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_cmd(input cmd_e c, input int unsigned pos,
                          input logic [WORD_W-1:0] data);
    in_word_t w;
    w.command  = c;
    w.position = POS_W'(pos);
    w.data_in  = data;
    send_word(w);
  endtask

  // Drain: wait until nothing is outstanding and the result reg has emptied.
  // The first edge lets the checker's count catch up with the last word.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; pready is tied high so one access.
  task automatic reg_write(input logic [PADDR_W-1:0] addr,
                           input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic cmd_e pick_cmd(input mix_e mix);
    int unsigned r;
    int unsigned g;
    r = $urandom_range(0, 99);
    g = (mix == MIX_GROW) ? 70 : (mix == MIX_EVEN) ? 50 : 30;
    if (r < g / 2) return CMD_INSERT;
    if (r < g) return CMD_APPEND;
    if (r < g + (100 - g) / 2) return CMD_REMOVE;
    return CMD_POP;
  endfunction

  // Mostly positions around the current fill so inserts and removes land;
  // the rest spans the legal range and the full 7-bit field.
  function automatic int unsigned pick_pos(input int unsigned size_now);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, size_now);
    if (r < 90) return $urandom_range(0, 64);
    return $urandom_range(0, 127);
  endfunction

  initial begin : stimulus
    int unsigned cap;
    mix_e        mix;
    int unsigned n_items;
    int unsigned ph;
    int unsigned k;
    int unsigned p;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part, capacity at its reset value ---
    send_cmd(CMD_POP,    0, 32'h0);            // pop on empty list
    send_cmd(CMD_REMOVE, 0, 32'h0);            // remove on empty list
    send_cmd(CMD_INSERT, 1, 32'h1111_1111);    // insert past end
    send_cmd(CMD_INSERT, 0, 32'hFFFF_FFFF);
    send_cmd(CMD_APPEND, 0, 32'h0000_0000);
    send_cmd(CMD_INSERT, 2, 32'h1234_5678);    // insert exactly at end
    send_cmd(CMD_INSERT, 1, 32'hA5A5_5A5A);    // shift of later words
    send_cmd(CMD_INSERT, 127, 32'h8000_0001);  // top of the position field
    send_cmd(CMD_REMOVE, 4, 32'h0);            // remove at size: out of range
    send_cmd(CMD_REMOVE, 1, 32'h0);
    send_cmd(CMD_POP,    0, 32'h0);

    // limit lowered to the current size: grows refused, shrinks still work
    wait_idle();
    reg_write(ADDR_CAP, 32'd2);
    send_cmd(CMD_APPEND, 0, 32'hDEAD_BEEF);
    send_cmd(CMD_INSERT, 3, 32'hDEAD_BEEF);    // range check before full check
    send_cmd(CMD_INSERT, 0, 32'hDEAD_BEEF);
    send_cmd(CMD_REMOVE, 0, 32'h0);

    // limit of zero refuses every grow
    wait_idle();
    reg_write(ADDR_CAP, 32'd0);
    send_cmd(CMD_APPEND, 0, 32'h7FFF_FFFF);
    send_cmd(CMD_POP,    0, 32'h0);
    send_cmd(CMD_POP,    0, 32'h0);

    // write to the empty register slot must leave the limit at zero
    wait_idle();
    reg_write(ADDR_UNUSED, 32'd64);
    send_cmd(CMD_APPEND, 0, 32'h0F0F_0F0F);
    send_cmd(CMD_INSERT, 0, 32'hF0F0_F0F0);

    // --- random part: one limit and one mix per phase ---
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin cap = 127; mix = MIX_GROW; n_items = 200; end  // limit above store
        1: begin cap = $urandom_range(2, 40); mix = MIX_EVEN; n_items = 120; end
        2: begin cap = 64; mix = MIX_SHRINK; n_items = 150; end
        3: begin cap = 1; mix = MIX_EVEN; n_items = 100; end
        4: begin cap = 0; mix = MIX_EVEN; n_items = 60; end
        5: begin cap = $urandom_range(65, 126); mix = MIX_GROW; n_items = 150; end
        6: begin cap = $urandom_range(1, 64); mix = MIX_SHRINK; n_items = 120; end
        default: begin cap = 64; mix = MIX_EVEN; n_items = 150; end
      endcase
      wait_idle();
      reg_write(ADDR_CAP, PDATA_W'(cap));
      // back-pressure the result side hard while commands keep coming
      if (ph == 2) long_hold_req = 1'b1;
      for (k = 0; k < n_items; k++) begin
        // re-roll idling now and then; the final phase runs flat out
        if (k % 40 == 0) begin
          tx_idle_en = (ph != 7) && ($urandom_range(0, 3) != 0);
          rx_idle_en = (ph != 7) && ($urandom_range(0, 3) != 0);
        end
        p = pick_pos(list_size);
        send_cmd(pick_cmd(mix), p, $urandom());
      end
    end

    wait_idle();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
